/* rtl/core/lpda_pkg.sv */
package lpda_pkg;

  localparam int LANES_DEF      = 4;
  localparam int INDEX_BITS_DEF = 8;
  // operand pairs that one input word carries
  localparam int IN_LANES       = 4;
  localparam int DATA_W         = 32;
  localparam int LCNT_W         = 3;
  // result queue, power of two
  localparam int FIFO_DEPTH     = 4;
  localparam int PTR_W          = $clog2(FIFO_DEPTH);
  localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ACC   = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

endpackage

/* rtl/core/lpda_lane.sv */
module lpda_lane #(
  parameter int INDEX_BITS = lpda_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [2*INDEX_BITS-1:0]         wr_addr,
  input  logic [lpda_pkg::DATA_W-1:0]     wr_data,
  input  logic                            rd_en,
  input  logic [2*INDEX_BITS-1:0]         rd_addr,
  input  logic                            lane_en,
  output logic [lpda_pkg::DATA_W-1:0]     prod
);

  localparam int DEPTH = 1 << (2 * INDEX_BITS);

  // private copy of the product table, rewritten in step with the other lanes
  logic [lpda_pkg::DATA_W-1:0] mem [DEPTH];
  logic [lpda_pkg::DATA_W-1:0] rd_data;
  logic                        active;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      active  <= lane_en;
    end
  end

  // lanes past the used count add nothing
  assign prod = active ? rd_data : '0;

endmodule

/* rtl/core/lpda_merge.sv */
module lpda_merge #(
  parameter int NUM = lpda_pkg::LANES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lpda_pkg::ctrl_t             s1,
  input  logic [lpda_pkg::DATA_W-1:0] lane_prod [NUM],
  output logic                        push,
  output logic [lpda_pkg::DATA_W-1:0] push_data,
  output logic [1:0]                  pend
);

  lpda_pkg::ctrl_t             s2;
  logic [lpda_pkg::DATA_W-1:0] part;
  logic [lpda_pkg::DATA_W-1:0] part_next;
  logic [lpda_pkg::DATA_W-1:0] acc;
  logic [lpda_pkg::DATA_W-1:0] acc_sum;

  always_comb begin
    part_next = '0;
    for (int k = 0; k < NUM; k++) begin
      part_next = part_next + lane_prod[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= s1;
    end
    part <= part_next;
  end

  assign acc_sum   = acc + part;
  assign push      = s2.valid & s2.last;
  assign push_data = acc_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2.valid) begin
      acc <= s2.last ? '0 : acc_sum;
    end
  end

  // results still on their way to the queue
  assign pend = {1'b0, s1.valid & s1.last} + {1'b0, s2.valid & s2.last};

endmodule

/* rtl/core/lpda_fifo.sv */
module lpda_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [lpda_pkg::DATA_W-1:0]    push_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [lpda_pkg::DATA_W-1:0]    out_data,
  output logic [lpda_pkg::CNT_W-1:0]     count
);

  logic [lpda_pkg::DATA_W-1:0] mem [lpda_pkg::FIFO_DEPTH];
  logic [lpda_pkg::PTR_W-1:0]  wr_ptr;
  logic [lpda_pkg::PTR_W-1:0]  rd_ptr;
  logic                        pop;

  function automatic logic [lpda_pkg::CNT_W-1:0] CNT_ONE(input logic b);
    CNT_ONE = {{(lpda_pkg::CNT_W-1){1'b0}}, b};
  endfunction

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_ONE(push) - CNT_ONE(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == lpda_pkg::CNT_W'(lpda_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  a_drop_only_on_pop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(pop))
    else $error("queued word lost without a pop");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(rd_ptr)))
    else $error("head word moved while stalled");

endmodule

/* rtl/core/lut_product_dot_accumulator_top.sv */
// channel | handshake            | payload
// in      | in_valid / in_stall   | op, a_byte_0..3, b_byte_0..3, table_value, lanes_used, last
// out     | out_valid / out_stall | dot_sum
//
// one input word per cycle while in_stall is low; a word with last goes through the lane
// table read, the lane sum and the accumulate into the queue, in that order, each registered
// each lane owns a copy of the product table with one read port; a table write updates all
// rst is synchronous and clears the pipeline, the running sum and the result queue
// in_stall is high while queued results plus results in flight fill the four-entry queue
// table contents are not cleared by rst and hold garbage until written
module lut_product_dot_accumulator_top #(
  parameter int LANES      = lpda_pkg::LANES_DEF,
  parameter int INDEX_BITS = lpda_pkg::INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [7:0]                  a_byte_0,
  input  logic [7:0]                  a_byte_1,
  input  logic [7:0]                  a_byte_2,
  input  logic [7:0]                  a_byte_3,
  input  logic [7:0]                  b_byte_0,
  input  logic [7:0]                  b_byte_1,
  input  logic [7:0]                  b_byte_2,
  input  logic [7:0]                  b_byte_3,
  input  logic signed [31:0]          table_value,
  input  logic [2:0]                  lanes_used,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          dot_sum
);

  localparam int NUM    = (LANES < lpda_pkg::IN_LANES) ? LANES : lpda_pkg::IN_LANES;
  localparam int ADDR_W = 2 * INDEX_BITS;

  logic [7:0]                  a_bytes [lpda_pkg::IN_LANES];
  logic [7:0]                  b_bytes [lpda_pkg::IN_LANES];
  logic [lpda_pkg::DATA_W-1:0] lane_prod [NUM];
  logic [ADDR_W-1:0]           wr_addr;
  logic                        accept;
  logic                        wr_en;
  logic                        rd_en;
  lpda_pkg::ctrl_t             s1;
  logic                        push;
  logic [lpda_pkg::DATA_W-1:0] push_data;
  logic [1:0]                  pend;
  logic [lpda_pkg::CNT_W-1:0]  fifo_count;
  logic [lpda_pkg::CNT_W:0]    credits;
  logic [lpda_pkg::DATA_W-1:0] out_data;

  assign a_bytes[0] = a_byte_0;
  assign a_bytes[1] = a_byte_1;
  assign a_bytes[2] = a_byte_2;
  assign a_bytes[3] = a_byte_3;
  assign b_bytes[0] = b_byte_0;
  assign b_bytes[1] = b_byte_1;
  assign b_bytes[2] = b_byte_2;
  assign b_bytes[3] = b_byte_3;

  assign credits  = {1'b0, fifo_count} + (lpda_pkg::CNT_W + 1)'(pend);
  assign in_stall = (credits >= (lpda_pkg::CNT_W + 1)'(lpda_pkg::FIFO_DEPTH));
  assign accept   = in_valid & ~in_stall;
  assign wr_en    = accept & (op == lpda_pkg::OP_WRITE);
  assign rd_en    = accept & (op == lpda_pkg::OP_ACC);
  assign wr_addr  = {a_byte_0[INDEX_BITS-1:0], b_byte_0[INDEX_BITS-1:0]};

  for (genvar k = 0; k < NUM; k++) begin : g_lane
    lpda_lane #(
      .INDEX_BITS(INDEX_BITS)
    ) u_lane (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (table_value),
      .rd_en   (rd_en),
      .rd_addr ({a_bytes[k][INDEX_BITS-1:0], b_bytes[k][INDEX_BITS-1:0]}),
      .lane_en (lanes_used > 3'(k)),
      .prod    (lane_prod[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1.valid <= rd_en;
      s1.last  <= last;
    end
  end

  lpda_merge #(
    .NUM(NUM)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .s1        (s1),
    .lane_prod (lane_prod),
    .push      (push),
    .push_data (push_data),
    .pend      (pend)
  );

  lpda_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  assign dot_sum = out_data;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= (lpda_pkg::CNT_W + 1)'(lpda_pkg::FIFO_DEPTH))
    else $error("results in flight exceed queue space");

  a_write_no_read: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !s1.valid)
    else $error("table write entered the accumulate path");

  a_read_tracks: assert property (@(posedge clk) disable iff (rst)
    (rd_en && last) |=> (s1.valid && s1.last && pend != 2'd0))
    else $error("closing word not counted as pending");

endmodule

/* tb/sv/lut_product_dot_accumulator_top_tb.sv */
module lut_product_dot_accumulator_top_tb;

  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 600;

  typedef struct packed {
    logic            op;
    logic [3:0][7:0] a;
    logic [3:0][7:0] b;
    logic [31:0]     value;
    logic [2:0]      lanes;
    logic            last;
  } word_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               op          = lpda_pkg::OP_WRITE;
  logic [7:0]         a_byte_0    = '0;
  logic [7:0]         a_byte_1    = '0;
  logic [7:0]         a_byte_2    = '0;
  logic [7:0]         a_byte_3    = '0;
  logic [7:0]         b_byte_0    = '0;
  logic [7:0]         b_byte_1    = '0;
  logic [7:0]         b_byte_2    = '0;
  logic [7:0]         b_byte_3    = '0;
  logic signed [31:0] table_value = '0;
  logic [2:0]         lanes_used  = '0;
  logic               last        = 1'b0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] dot_sum;

  // shadow of the product table and of the running sum
  logic [31:0]        lut_shadow [0:65535];
  bit                 lut_written [0:65535];
  logic [15:0]        written_keys [$];
  logic [31:0]        run_sum = '0;
  logic signed [31:0] dot_sum_expected [$];

  bit in_fire    = 1'b0;
  bit out_fire   = 1'b0;
  int fail_count = 0;
  int sent_words = 0;
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  int hold_token = 0;

  lut_product_dot_accumulator_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void update_dot_prediction();
    logic [7:0] ra [4];
    logic [7:0] rb [4];
    logic [15:0] key;
    int n;
    ra = '{a_byte_0, a_byte_1, a_byte_2, a_byte_3};
    rb = '{b_byte_0, b_byte_1, b_byte_2, b_byte_3};
    if (op == lpda_pkg::OP_WRITE) begin
      // with eight index bits the row and column are the whole bytes
      key = {a_byte_0, b_byte_0};
      lut_shadow[key] = table_value;
      if (!lut_written[key]) begin
        lut_written[key] = 1'b1;
        written_keys.push_back(key);
      end
      return;
    end
    n = (lanes_used > lpda_pkg::LANES_DEF) ? lpda_pkg::LANES_DEF : int'(lanes_used);
    if (n > lpda_pkg::IN_LANES) n = lpda_pkg::IN_LANES;
    for (int k = 0; k < n; k++) run_sum += lut_shadow[{ra[k], rb[k]}];
    if (last) begin
      dot_sum_expected.push_back(run_sum);
      run_sum = '0;
    end
  endfunction

  function automatic void check_dot_sum();
    logic signed [31:0] want;
    if (dot_sum_expected.size() == 0) begin
      $error("dot_sum: expected none, actual %0d", dot_sum);
      fail_count++;
      return;
    end
    want = dot_sum_expected.pop_front();
    if (dot_sum !== want) begin
      $error("dot_sum: expected %0d, actual %0d", want, dot_sum);
      fail_count++;
    end
  endfunction

  // handshakes are settled mid-cycle, where nothing is changing
  always @(negedge clk) begin
    in_fire  = !rst && in_valid && !in_stall;
    out_fire = !rst && out_valid && !out_stall;
    if (out_fire) check_dot_sum();
    if (in_fire) update_dot_prediction();
  end

  // receiver: shifting stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    static stall_mode_t stall_mode = STALL_NONE;
    static int mode_left = 0;
    static int hold_left = 0;
    static int hold_served = 0;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_token != hold_served) begin
      hold_served = hold_token;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(9) < 6);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("lut_product_dot_accumulator_top verification failed");
    $finish;
  end

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(input word_t w);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left != 0) burst_left--;
    op          <= w.op;
    a_byte_0    <= w.a[0];
    a_byte_1    <= w.a[1];
    a_byte_2    <= w.a[2];
    a_byte_3    <= w.a[3];
    b_byte_0    <= w.b[0];
    b_byte_1    <= w.b[1];
    b_byte_2    <= w.b[2];
    b_byte_3    <= w.b[3];
    table_value <= w.value;
    lanes_used  <= w.lanes;
    last        <= w.last;
    in_valid    <= 1'b1;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent_words++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (dot_sum_expected.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic word_t lut_write_word(input logic [7:0] row, input logic [7:0] col,
                                           input logic [31:0] value);
    word_t w;
    w.op    = lpda_pkg::OP_WRITE;
    w.a     = {24'($urandom), row};
    w.b     = {24'($urandom), col};
    w.value = value;
    w.lanes = 3'($urandom);
    w.last  = 1'($urandom);
    return w;
  endfunction

  function automatic word_t dot_word(input logic [3:0][15:0] keys, input logic [2:0] lanes,
                                     input logic is_last);
    word_t w;
    w.op    = lpda_pkg::OP_ACC;
    w.value = $urandom;
    w.lanes = lanes;
    w.last  = is_last;
    for (int k = 0; k < 4; k++) begin
      w.a[k] = keys[k][15:8];
      w.b[k] = keys[k][7:0];
    end
    return w;
  endfunction

  // every lane, used or not, points at an entry that holds a value
  function automatic logic [3:0][15:0] pick_keys();
    logic [3:0][15:0] keys;
    for (int k = 0; k < 4; k++)
      keys[k] = written_keys[$urandom_range(written_keys.size() - 1)];
    return keys;
  endfunction

  task automatic test_table_corners();
    send_word(lut_write_word(8'h00, 8'h00, 32'h7fff_ffff));
    send_word(lut_write_word(8'hff, 8'hff, 32'h8000_0000));
    send_word(lut_write_word(8'h00, 8'hff, 32'hffff_ffff));
    send_word(lut_write_word(8'hff, 8'h00, 32'h0000_0001));
    send_word(lut_write_word(8'ha5, 8'h5a, 32'h0000_0000));
    send_word(lut_write_word(8'h5a, 8'ha5, 32'h1234_5678));
  endtask

  task automatic test_lane_counts();
    // entry ff/00 holds one, so each sum is the clamped lane count
    for (int n = 0; n < 8; n++)
      send_word(dot_word({4{16'hff00}}, 3'(n), 1'b1));
    // wraps past the top, with a table write inside the open sum
    send_word(dot_word({4{16'h0000}}, 3'd2, 1'b0));
    send_word(lut_write_word(8'h5a, 8'ha5, 32'hdead_beef));
    send_word(dot_word({16'h5aa5, 16'h00ff, 16'hffff, 16'h0000}, 3'd4, 1'b1));
  endtask

  task automatic test_write_then_read();
    gaps_on = 1'b0;
    send_word(lut_write_word(8'h33, 8'hcc, $urandom));
    send_word(dot_word({4{16'h33cc}}, 3'd4, 1'b1));
    send_word(lut_write_word(8'h33, 8'hcc, $urandom));
    send_word(dot_word({16'h0000, 16'h33cc, 16'h0000, 16'h33cc}, 3'd4, 1'b1));
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_token <= hold_token + 1;
    // offer forty closing words while the receiver holds off, so the result queue backs up into in_stall
    repeat (40) send_word(dot_word(pick_keys(), 3'd4, 1'b1));
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int pick;
    int len;
    logic [15:0] key;
    logic [3:0][15:0] keys;
    stop_at = sent_words + RANDOM_WORDS;
    while (sent_words < stop_at) begin
      gaps_on = ((sent_words / 100) % 3) != 2;
      pick = $urandom_range(99);
      if (pick < 12) begin
        keys = pick_keys();
        key = ($urandom_range(2) == 0) ? keys[0] : 16'($urandom);
        send_word(lut_write_word(key[15:8], key[7:0], $urandom));
      end else if (pick < 17) begin
        send_word(dot_word(pick_keys(), 3'($urandom), 1'($urandom)));
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) begin
            keys = pick_keys();
            key = ($urandom_range(1) == 0) ? keys[0] : 16'($urandom);
            send_word(lut_write_word(key[15:8], key[7:0], $urandom));
          end
          send_word(dot_word(pick_keys(),
                             ($urandom_range(7) == 0) ? 3'($urandom_range(7))
                                                      : 3'($urandom_range(1, 4)),
                             i == len - 1));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_table_corners();
    test_lane_counts();
    test_write_then_read();
    drain_results();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) begin
      $display("lut_product_dot_accumulator_top verification clean");
    end else begin
      $display("lut_product_dot_accumulator_top verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lpda_pkg.sv
rtl/core/lpda_lane.sv
rtl/core/lpda_merge.sv
rtl/core/lpda_fifo.sv
rtl/core/lut_product_dot_accumulator_top.sv
tb/sv/lut_product_dot_accumulator_top_tb.sv
